// ===== rtl/htlog_pkg.sv =====
// package: sizes, constants, register indexes and beat types of the thermostat
package htlog_pkg;

   localparam int LOG_DEPTH = 24;
   localparam int LOG_IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int HOUR_EXT_W = 7;
   localparam int LOG_W = 14;
   localparam int TEMP_W = 12;
   localparam int CALC_W = 13;
   localparam int SETPOINT_W = 7;
   localparam int HYST_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam int TENTHS_PER_DEGREE = 10;
   localparam int LOG_OFFSET = 1000;
   localparam int LOG_HEAT_FLAG = 10000;

   localparam logic [SETPOINT_W-1:0] DAY_SETPOINT_RESET = 7'd26;
   localparam logic [SETPOINT_W-1:0] NIGHT_SETPOINT_RESET = 7'd24;
   localparam logic [HYST_W-1:0] HYST_RESET = 8'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DAY_SETPOINT   = 3'd0,
      CSR_NIGHT_SETPOINT = 3'd1,
      CSR_DAY_ENABLE     = 3'd2,
      CSR_NIGHT_ENABLE   = 3'd3,
      CSR_HYSTERESIS     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              is_day;
      logic [5:0]        minute_now;
      logic [4:0]        hour_now;
      logic              sensor_ok;
      logic signed [11:0] temp_tenths;
      logic [4:0]        log_read_hour;
   } req_payload_type;

   typedef struct packed {
      logic              heater_on;
      logic [13:0]       log_read_value;
   } rsp_payload_type;

endpackage

// ===== rtl/hysteresis_thermostat_with_hour_log.sv =====
// top level: hysteresis thermostat with a per-hour temperature log
//
// One beat in, one beat out. A request beat is captured in an input register,
// the heater decision and log update are made by short compare and add logic,
// and the response lands in an output register. A new request can be taken
// every cycle as long as rsp_stall does not hold the output. The input
// register keeps taking one beat while a finished response waits under
// rsp_stall. The 24-entry hour log is cleared by reset at once, and a read
// of the hour being written in the same beat returns the new entry.
// Configuration is written through the csr port (always ready); the user
// must do so only while no beat is in flight; the block does not enforce it.
module hysteresis_thermostat_with_hour_log (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  htlog_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output htlog_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [htlog_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [htlog_pkg::CSR_DATA_W-1:0]      csr_data
);

   // configuration
   logic [htlog_pkg::SETPOINT_W-1:0] day_sp_ff, night_sp_ff;
   logic                             day_en_ff, night_en_ff;
   logic [htlog_pkg::HYST_W-1:0]     hyst_ff;

   // pipeline
   logic                             s1_valid_ff;
   htlog_pkg::req_payload_type       s1_ff;
   logic                             rsp_valid_ff;
   htlog_pkg::rsp_payload_type       rsp_ff;
   htlog_pkg::rsp_payload_type       rsp_in;
   logic                             s2_load;
   logic                             s1_load;

   // state
   logic                             heater_ff;
   logic                             heater_in;
   logic [htlog_pkg::LOG_W-1:0]      log_ff [htlog_pkg::LOG_DEPTH];

   // datapath
   logic [htlog_pkg::SETPOINT_W-1:0] setpoint_sel;
   logic                             enable_sel;
   logic signed [htlog_pkg::CALC_W-1:0] sp_tenths, band, hi_limit, lo_limit;
   logic signed [htlog_pkg::CALC_W-1:0] temp_ext, log_base;
   logic [htlog_pkg::LOG_W-1:0]      base_clip, entry;
   logic [htlog_pkg::HOUR_EXT_W-1:0] wr_hour_ext, rd_hour_ext;
   logic [htlog_pkg::LOG_IDX_W-1:0]  wr_idx, rd_idx;
   logic                             wr_hit, rd_in_range, log_write;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         day_sp_ff   <= htlog_pkg::DAY_SETPOINT_RESET;
         night_sp_ff <= htlog_pkg::NIGHT_SETPOINT_RESET;
         day_en_ff   <= 1'b1;
         night_en_ff <= 1'b1;
         hyst_ff     <= htlog_pkg::HYST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            htlog_pkg::CSR_DAY_SETPOINT: begin
               day_sp_ff <= csr_data[htlog_pkg::SETPOINT_W-1:0];
            end
            htlog_pkg::CSR_NIGHT_SETPOINT: begin
               night_sp_ff <= csr_data[htlog_pkg::SETPOINT_W-1:0];
            end
            htlog_pkg::CSR_DAY_ENABLE: begin
               day_en_ff <= csr_data[0];
            end
            htlog_pkg::CSR_NIGHT_ENABLE: begin
               night_en_ff <= csr_data[0];
            end
            htlog_pkg::CSR_HYSTERESIS: begin
               hyst_ff <= csr_data[htlog_pkg::HYST_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   // heater decision
   always_comb begin
      setpoint_sel = s1_ff.is_day ? day_sp_ff : night_sp_ff;
      enable_sel   = s1_ff.is_day ? day_en_ff : night_en_ff;
      sp_tenths    = signed'(htlog_pkg::CALC_W'(setpoint_sel)
                     * htlog_pkg::CALC_W'(htlog_pkg::TENTHS_PER_DEGREE));
      band         = signed'(htlog_pkg::CALC_W'(hyst_ff));
      hi_limit     = sp_tenths + band;
      lo_limit     = sp_tenths - band;
      temp_ext     = {s1_ff.temp_tenths[htlog_pkg::TEMP_W-1], s1_ff.temp_tenths};
      if (heater_ff) begin
         heater_in = !(!enable_sel || !s1_ff.sensor_ok || temp_ext >= hi_limit);
      end else begin
         heater_in = enable_sel && s1_ff.sensor_ok && temp_ext <= lo_limit;
      end
   end

   // log entry, write and read
   always_comb begin
      log_base  = temp_ext + signed'(htlog_pkg::CALC_W'(htlog_pkg::LOG_OFFSET));
      base_clip = (s1_ff.sensor_ok && !log_base[htlog_pkg::CALC_W-1])
                  ? htlog_pkg::LOG_W'(log_base[htlog_pkg::CALC_W-2:0]) : '0;
      entry     = base_clip + (heater_in ? htlog_pkg::LOG_W'(htlog_pkg::LOG_HEAT_FLAG) : '0);

      wr_hour_ext = htlog_pkg::HOUR_EXT_W'(s1_ff.hour_now);
      rd_hour_ext = htlog_pkg::HOUR_EXT_W'(s1_ff.log_read_hour);
      wr_idx      = wr_hour_ext[htlog_pkg::LOG_IDX_W-1:0];
      rd_idx      = rd_hour_ext[htlog_pkg::LOG_IDX_W-1:0];
      wr_hit      = (s1_ff.minute_now == '0)
                    && (wr_hour_ext < htlog_pkg::HOUR_EXT_W'(htlog_pkg::LOG_DEPTH));
      rd_in_range = rd_hour_ext < htlog_pkg::HOUR_EXT_W'(htlog_pkg::LOG_DEPTH);
      log_write   = s1_valid_ff && s2_load && wr_hit;

      rsp_in.heater_on = heater_in;
      if (!rd_in_range) begin
         rsp_in.log_read_value = '0;
      end else if (wr_hit && wr_idx == rd_idx) begin
         rsp_in.log_read_value = entry;
      end else begin
         rsp_in.log_read_value = log_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         heater_ff    <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_load) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               heater_ff <= heater_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_ff <= req_payload;
      end
      if (s2_load && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < htlog_pkg::LOG_DEPTH; i++) begin
            log_ff[i] <= '0;
         end
      end else if (log_write) begin
         log_ff[wr_idx] <= entry;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
